/* src/magma_channel_permeability_defines.svh */
// Shared assertion macros. Each one uses the clk and rst_n of the module it sits in.
`ifndef MAGMA_CHANNEL_PERMEABILITY_DEFINES_SVH
`define MAGMA_CHANNEL_PERMEABILITY_DEFINES_SVH

// Same-cycle implication, off while in reset
`define MAGCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset
`define MAGCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/magcp_pkg.sv */
package magcp_pkg;

    // Fraction format
    localparam int FRAC_BITS = 16;
    localparam int FW        = FRAC_BITS + 1;
    localparam int FONE_I    = 1 << FRAC_BITS;

    // Payload widths
    localparam int PW    = 48;          // permeability
    localparam int IW    = 51;          // intrinsic permeability
    localparam int RW    = 32;          // relative permeability, Q30
    localparam int ACC_W = 40;          // Horner accumulator, Q30 signed
    localparam int UP_W  = 33;          // clamped intrinsic polynomial, 0..2^32

    // Config port
    localparam int NUM_REGS = 6;
    localparam int DW       = 64;
    localparam int AW       = $clog2(NUM_REGS) + 3;

    localparam logic [FW-1:0] FONE = FW'(FONE_I);

    // Register reset values
    localparam logic [PW-1:0] MAX_PERM_RST = PW'(10000000);
    localparam logic [FW-1:0] CRY_LO_RST   = FW'((FONE_I * 4 + 5) / 10);
    localparam logic [FW-1:0] CRY_HI_RST   = FW'((FONE_I * 7 + 5) / 10);
    localparam logic [FW-1:0] CARRIER_RST  = FW'(FONE_I / 2);
    localparam logic [FW-1:0] SOLID_RST    = FW'((FONE_I * 99 + 50) / 100);
    localparam logic [FW-1:0] MELT_RST     = FW'(FONE_I / 2);

    typedef enum logic [$clog2(NUM_REGS)-1:0] {
        REG_MAX_PERM = 0,
        REG_CRY_LO   = 1,
        REG_CRY_HI   = 2,
        REG_CARRIER  = 3,
        REG_SOLID    = 4,
        REG_MELT     = 5
    } reg_idx_t;

    typedef enum logic [1:0] {
        RGM_CARRIER    = 2'd0,
        RGM_SUSPENSION = 2'd1,
        RGM_CHANNELS   = 2'd2,
        RGM_TRAPPED    = 2'd3
    } regime_t;

    typedef enum logic [1:0] {
        FM_NONE    = 2'd0,
        FM_TRAPPED = 2'd1,
        FM_SOLID   = 2'd2
    } fmode_t;

    typedef struct packed {
        logic [PW-1:0] perm_cap;
        logic [FW-1:0] cry_lo;
        logic [FW-1:0] cry_hi;
        logic [FW-1:0] carrier_vol;
        logic [FW-1:0] solid_cryst;
        logic [FW-1:0] melt_lim;
    } cfg_t;

    typedef struct packed {
        logic [FW-1:0] vol;
        logic [FW-1:0] melt;
        logic [FW-1:0] cry;
        logic [FW-1:0] cryst;
        logic [PW-1:0] perm;
        logic [PW-1:0] vert_perm;
        logic [PW-1:0] horiz_perm;
    } item_t;

    // Polynomial front end result
    typedef struct packed {
        item_t                   item;
        logic [FW-1:0]           crit;
        logic [UP_W-1:0]         intr_q30;
        logic signed [ACC_W-1:0] rel_raw;
    } poly_t;

    typedef struct packed {
        regime_t              regime;
        logic                 porous;
        fmode_t               fracture_mode;
        logic                 channel_marked;
        logic [FW-1:0]        critical_volatile;
        logic [IW-1:0]        intrinsic_perm;
        logic signed [RW-1:0] relative_perm;
        logic [PW-1:0]        channel_perm;
        logic [PW-1:0]        perm_out;
        logic [PW-1:0]        vert_perm_out;
        logic [PW-1:0]        horiz_perm_out;
    } res_t;

endpackage

/* src/magcp_in_if.sv */
interface magcp_in_if;
    import magcp_pkg::*;

    logic          valid;
    logic          ready;
    logic [FW-1:0] volatile_frac;
    logic [FW-1:0] melt_frac;
    logic [FW-1:0] crystal_frac;
    logic [FW-1:0] crystallinity_in;
    logic [PW-1:0] perm_in;
    logic [PW-1:0] vert_perm_in;
    logic [PW-1:0] horiz_perm_in;

    modport source
    (
        output valid, volatile_frac, melt_frac, crystal_frac, crystallinity_in,
        output perm_in, vert_perm_in, horiz_perm_in,
        input  ready
    );

    modport sink
    (
        input  valid, volatile_frac, melt_frac, crystal_frac, crystallinity_in,
        input  perm_in, vert_perm_in, horiz_perm_in,
        output ready
    );
endinterface

/* src/magcp_out_if.sv */
interface magcp_out_if;
    import magcp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           regime;
    logic                 porous;
    logic [1:0]           fracture_mode;
    logic                 channel_marked;
    logic [FW-1:0]        critical_volatile;
    logic [IW-1:0]        intrinsic_perm;
    logic signed [RW-1:0] relative_perm;
    logic [PW-1:0]        channel_perm;
    logic [PW-1:0]        perm_out;
    logic [PW-1:0]        vert_perm_out;
    logic [PW-1:0]        horiz_perm_out;

    modport source
    (
        output valid, regime, porous, fracture_mode, channel_marked, critical_volatile,
        output intrinsic_perm, relative_perm, channel_perm,
        output perm_out, vert_perm_out, horiz_perm_out,
        input  ready
    );

    modport sink
    (
        input  valid, regime, porous, fracture_mode, channel_marked, critical_volatile,
        input  intrinsic_perm, relative_perm, channel_perm,
        input  perm_out, vert_perm_out, horiz_perm_out,
        output ready
    );
endinterface

/* src/magma_channel_permeability.sv */
// An accepted input beat passes through eight register stages to its result beat on the output.
// Throughput: one item per cycle while the output accepts; each register stage has at most one
// multiply on any path (Horner steps, intrinsic scaling, split channel product).
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n, async, active low) clears all valid bits and loads the register defaults.
module magma_channel_permeability
(
    input  logic                       clk,
    input  logic                       rst_n,
    magcp_in_if.sink                   item,
    magcp_out_if.source                result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [magcp_pkg::AW-1:0]   paddr,
    input  logic [magcp_pkg::DW-1:0]   pwdata,
    output logic [magcp_pkg::DW-1:0]   prdata,
    output logic                       pready
);
    import magcp_pkg::*;

    cfg_t  cfg;
    item_t in_item;
    poly_t poly;
    logic  poly_valid;
    res_t  res;
    logic  res_valid;
    logic  adv;

    // Pipeline moves when the output register is empty or being drained
    assign adv        = !res_valid || result.ready;
    assign item.ready = adv;

    assign in_item.vol        = item.volatile_frac;
    assign in_item.melt       = item.melt_frac;
    assign in_item.cry        = item.crystal_frac;
    assign in_item.cryst      = item.crystallinity_in;
    assign in_item.perm       = item.perm_in;
    assign in_item.vert_perm  = item.vert_perm_in;
    assign in_item.horiz_perm = item.horiz_perm_in;

    magcp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    magcp_poly u_poly
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (item.valid),
        .in_item   (in_item),
        .out_valid (poly_valid),
        .out_poly  (poly)
    );

    magcp_chan u_chan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (poly_valid),
        .in_poly   (poly),
        .out_valid (res_valid),
        .out_res   (res)
    );

    // Result beat
    assign result.valid             = res_valid;
    assign result.regime            = res.regime;
    assign result.porous            = res.porous;
    assign result.fracture_mode     = res.fracture_mode;
    assign result.channel_marked    = res.channel_marked;
    assign result.critical_volatile = res.critical_volatile;
    assign result.intrinsic_perm    = res.intrinsic_perm;
    assign result.relative_perm     = res.relative_perm;
    assign result.channel_perm      = res.channel_perm;
    assign result.perm_out          = res.perm_out;
    assign result.vert_perm_out     = res.vert_perm_out;
    assign result.horiz_perm_out    = res.horiz_perm_out;

endmodule

/* src/magcp_cfg.sv */
module magcp_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [magcp_pkg::AW-1:0]   paddr,
    input  logic [magcp_pkg::DW-1:0]   pwdata,
    output logic [magcp_pkg::DW-1:0]   prdata,
    output logic                       pready,
    output magcp_pkg::cfg_t            cfg
);
    import magcp_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    // 64-bit registers, so the index sits above the byte-in-word bits
    assign idx    = reg_idx_t'(paddr[AW-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.perm_cap    <= MAX_PERM_RST;
            cfg_reg.cry_lo      <= CRY_LO_RST;
            cfg_reg.cry_hi      <= CRY_HI_RST;
            cfg_reg.carrier_vol <= CARRIER_RST;
            cfg_reg.solid_cryst <= SOLID_RST;
            cfg_reg.melt_lim    <= MELT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MAX_PERM: cfg_reg.perm_cap    <= pwdata[PW-1:0];
                REG_CRY_LO:   cfg_reg.cry_lo      <= pwdata[FW-1:0];
                REG_CRY_HI:   cfg_reg.cry_hi      <= pwdata[FW-1:0];
                REG_CARRIER:  cfg_reg.carrier_vol <= pwdata[FW-1:0];
                REG_SOLID:    cfg_reg.solid_cryst <= pwdata[FW-1:0];
                REG_MELT:     cfg_reg.melt_lim    <= pwdata[FW-1:0];
                default:      ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_MAX_PERM: prdata = DW'(cfg_reg.perm_cap);
            REG_CRY_LO:   prdata = DW'(cfg_reg.cry_lo);
            REG_CRY_HI:   prdata = DW'(cfg_reg.cry_hi);
            REG_CARRIER:  prdata = DW'(cfg_reg.carrier_vol);
            REG_SOLID:    prdata = DW'(cfg_reg.solid_cryst);
            REG_MELT:     prdata = DW'(cfg_reg.melt_lim);
            default:      prdata = '0;
        endcase
    end

endmodule

/* src/magcp_poly.sv */
module magcp_poly
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  magcp_pkg::item_t  in_item,
    output logic              out_valid,
    output magcp_pkg::poly_t  out_poly
);
    import magcp_pkg::*;

    localparam int PROD_W = ACC_W + FW + 1;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    // Q30 coefficients, highest power first
    localparam logic signed [ACC_W-1:0] CRIT_C0 = 40'sd804769497;
    localparam logic signed [ACC_W-1:0] CRIT_C1 = -40'sd458273010;
    localparam logic signed [ACC_W-1:0] CRIT_C2 = -40'sd174590421;
    localparam logic signed [ACC_W-1:0] CRIT_C3 = 40'sd158699042;

    localparam logic signed [ACC_W-1:0] REL_C0 = -40'sd2338394944;
    localparam logic signed [ACC_W-1:0] REL_C1 = 40'sd5530951510;
    localparam logic signed [ACC_W-1:0] REL_C2 = -40'sd4853205670;
    localparam logic signed [ACC_W-1:0] REL_C3 = 40'sd1866700161;
    localparam logic signed [ACC_W-1:0] REL_C4 = -40'sd264247863;

    localparam logic signed [ACC_W-1:0] INTR_C0 = -40'sd57337813;
    localparam logic signed [ACC_W-1:0] INTR_C1 = 40'sd116286240;
    localparam logic signed [ACC_W-1:0] INTR_C2 = -40'sd80208514;
    localparam logic signed [ACC_W-1:0] INTR_C3 = 40'sd18897856;

    localparam logic signed [ACC_W-1:0] FONE_ACC = ACC_W'(FONE_I);
    localparam logic signed [ACC_W-1:0] UP_LIM   = ACC_W'(1) << 32;

    // acc * x / 2^FRAC_BITS, rounding half away from zero
    function automatic logic signed [ACC_W-1:0] mul_frac
    (
        input logic signed [ACC_W-1:0] acc,
        input logic [FW-1:0]           x
    );
        logic signed [PROD_W-1:0] p;
        logic [PROD_W-1:0]        mag;
        logic [PROD_W-1:0]        q;
        p   = acc * $signed({1'b0, x});
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        q   = (mag + HALF) >> FRAC_BITS;
        mul_frac = p[PROD_W-1] ? -$signed(q[ACC_W-1:0]) : $signed(q[ACC_W-1:0]);
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    item_t it1_reg, it2_reg, it3_reg;
    logic signed [ACC_W-1:0] crit1_reg, intr1_reg, rel1_reg;
    logic signed [ACC_W-1:0] crit2_reg, intr2_reg, rel2_reg;
    logic signed [ACC_W-1:0] rel3_reg;
    logic [FW-1:0]           crit3_reg;
    logic [UP_W-1:0]         up3_reg;
    poly_t                   poly4_reg;

    logic signed [ACC_W-1:0] crit1_next, intr1_next, rel1_next;
    logic signed [ACC_W-1:0] crit2_next, intr2_next, rel2_next;
    logic signed [ACC_W-1:0] crit3_sum, intr3_sum, rel3_next, rel4_next;
    logic [FW-1:0]           crit3_next;
    logic [UP_W-1:0]         up3_next;

    // One Horner step per stage for each polynomial still being evaluated
    always_comb
    begin
        crit1_next = mul_frac(CRIT_C0, in_item.cry) + CRIT_C1;
        intr1_next = mul_frac(INTR_C0, in_item.cry) + INTR_C1;
        rel1_next  = mul_frac(REL_C0, in_item.cry) + REL_C1;

        crit2_next = mul_frac(crit1_reg, it1_reg.cry) + CRIT_C2;
        intr2_next = mul_frac(intr1_reg, it1_reg.cry) + INTR_C2;
        rel2_next  = mul_frac(rel1_reg, it1_reg.cry) + REL_C2;

        crit3_sum  = mul_frac(crit2_reg, it2_reg.cry) + CRIT_C3;
        intr3_sum  = mul_frac(intr2_reg, it2_reg.cry) + INTR_C3;
        rel3_next  = mul_frac(rel2_reg, it2_reg.cry) + REL_C3;

        rel4_next  = mul_frac(rel3_reg, it3_reg.cry) + REL_C4;
    end

    // Critical fraction clamps to [0, one]; intrinsic cubic to [0, 2^32]
    always_comb
    begin
        if (crit3_sum[ACC_W-1])
            crit3_next = '0;
        else if (crit3_sum > FONE_ACC)
            crit3_next = FONE;
        else
            crit3_next = crit3_sum[FW-1:0];

        if (intr3_sum[ACC_W-1])
            up3_next = '0;
        else if (intr3_sum > UP_LIM)
            up3_next = UP_LIM[UP_W-1:0];
        else
            up3_next = intr3_sum[UP_W-1:0];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it1_reg   <= in_item;
            crit1_reg <= crit1_next;
            intr1_reg <= intr1_next;
            rel1_reg  <= rel1_next;

            it2_reg   <= it1_reg;
            crit2_reg <= crit2_next;
            intr2_reg <= intr2_next;
            rel2_reg  <= rel2_next;

            it3_reg   <= it2_reg;
            crit3_reg <= crit3_next;
            up3_reg   <= up3_next;
            rel3_reg  <= rel3_next;

            poly4_reg.item     <= it3_reg;
            poly4_reg.crit     <= crit3_reg;
            poly4_reg.intr_q30 <= up3_reg;
            poly4_reg.rel_raw  <= rel4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_poly  = poly4_reg;

endmodule

/* src/magcp_chan.sv */
`include "magma_channel_permeability_defines.svh"

module magcp_chan
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  magcp_pkg::cfg_t   cfg,
    input  logic              in_valid,
    input  magcp_pkg::poly_t  in_poly,
    output logic              out_valid,
    output magcp_pkg::res_t   out_res
);
    import magcp_pkg::*;

    // 1e18 / 2^30 = SCALE_INT + SCALE_FRAC / 4096
    localparam int SCALE_SH = 12;
    localparam logic [29:0] SCALE_INT  = 30'd931322574;
    localparam logic [11:0] SCALE_FRAC = 12'd2521;
    localparam int HI_W  = UP_W + 30;
    localparam int LO_W  = UP_W + SCALE_SH;
    localparam int SUM_W = HI_W + 1;
    localparam int Q     = 30;
    localparam int PA_W  = IW - Q + RW - 1;
    localparam int PB_W  = Q + RW - 1;
    localparam int CH_W  = PA_W + 1;
    localparam logic signed [RW-1:0] REL_ONE = RW'(1) << Q;

    typedef struct packed {
        item_t                item;
        regime_t              regime;
        fmode_t               fmode;
        logic [FW-1:0]        crit;
        logic signed [RW-1:0] rel;
    } ctl_t;

    logic v5_reg, v6_reg, v7_reg;
    logic res_valid_reg;
    ctl_t ctl5_reg, ctl6_reg, ctl7_reg;
    logic [HI_W-1:0] hi5_reg;
    logic [LO_W-1:0] lo5_reg;
    logic [IW-1:0]   intr6_reg, intr7_reg;
    logic [RW-2:0]   r6_reg;
    logic [PA_W-1:0] pa7_reg;
    logic [PB_W-1:0] pb7_reg;
    res_t            res_reg;

    ctl_t            ctl5_next;
    logic            carrier;
    logic [HI_W-1:0] hi5_next;
    logic [LO_W-1:0] lo5_next;
    logic [SUM_W-1:0] intr_sum;
    logic [IW-1:0]   intr6_next;
    logic [RW-2:0]   r6_next;
    logic [PA_W-1:0] pa7_next;
    logic [PB_W-1:0] pb7_next;
    logic [CH_W-1:0] chan_sum;
    logic [PW-1:0]   chan_clamp;
    res_t            res_next;

    // Stage 5: regime, fracture mode, relative saturation, intrinsic scaling products
    always_comb
    begin
        ctl5_next.item = in_poly.item;
        ctl5_next.crit = in_poly.crit;
        carrier = in_poly.item.vol >= cfg.carrier_vol;

        priority if (carrier)
            ctl5_next.regime = RGM_CARRIER;
        else if (in_poly.item.cry < cfg.cry_lo)
            ctl5_next.regime = RGM_SUSPENSION;
        else if (in_poly.item.cry <= cfg.cry_hi && in_poly.item.vol >= in_poly.crit
                 && in_poly.item.cryst != FONE)
            ctl5_next.regime = RGM_CHANNELS;
        else
            ctl5_next.regime = RGM_TRAPPED;

        priority if (in_poly.item.cryst >= cfg.solid_cryst || in_poly.item.cry >= cfg.cry_hi
                     || (in_poly.item.melt <= cfg.melt_lim && carrier))
            ctl5_next.fmode = FM_SOLID;
        else if (ctl5_next.regime == RGM_TRAPPED)
            ctl5_next.fmode = FM_TRAPPED;
        else
            ctl5_next.fmode = FM_NONE;

        // Saturate quartic to 32-bit signed
        if (in_poly.rel_raw[ACC_W-1:RW-1] == '0 || in_poly.rel_raw[ACC_W-1:RW-1] == '1)
            ctl5_next.rel = in_poly.rel_raw[RW-1:0];
        else if (in_poly.rel_raw[ACC_W-1])
            ctl5_next.rel = {1'b1, {(RW-1){1'b0}}};
        else
            ctl5_next.rel = {1'b0, {(RW-1){1'b1}}};

        hi5_next = HI_W'(in_poly.intr_q30) * HI_W'(SCALE_INT);
        lo5_next = LO_W'(in_poly.intr_q30) * LO_W'(SCALE_FRAC);
    end

    // Stage 6: intrinsic sum with saturation; positive part of relative
    always_comb
    begin
        intr_sum = SUM_W'(hi5_reg)
                 + SUM_W'((lo5_reg + (LO_W'(1) << (SCALE_SH - 1))) >> SCALE_SH);
        intr6_next = (|intr_sum[SUM_W-1:IW]) ? {IW{1'b1}} : intr_sum[IW-1:0];
        r6_next = (!ctl5_reg.rel[RW-1] && |ctl5_reg.rel) ? ctl5_reg.rel[RW-2:0] : '0;
    end

    // Stage 7: split product of intrinsic and relative
    always_comb
    begin
        pa7_next = PA_W'(intr6_reg[IW-1:Q]) * PA_W'(r6_reg);
        pb7_next = PB_W'(intr6_reg[Q-1:0]) * PB_W'(r6_reg);
    end

    // Stage 8: recombine, clamp, select per regime
    always_comb
    begin
        chan_sum = CH_W'(pa7_reg) + CH_W'((pb7_reg + (PB_W'(1) << (Q - 1))) >> Q);
        chan_clamp = (chan_sum > CH_W'(cfg.perm_cap)) ? cfg.perm_cap : chan_sum[PW-1:0];

        res_next.regime            = ctl7_reg.regime;
        res_next.porous            = ctl7_reg.regime == RGM_CHANNELS
                                     || ctl7_reg.regime == RGM_TRAPPED;
        res_next.fracture_mode     = ctl7_reg.fmode;
        res_next.channel_marked    = ctl7_reg.regime == RGM_CHANNELS;
        res_next.critical_volatile = ctl7_reg.crit;

        unique case (ctl7_reg.regime)
            RGM_CHANNELS:
            begin
                res_next.intrinsic_perm = intr7_reg;
                res_next.relative_perm  = ctl7_reg.rel;
                res_next.channel_perm   = chan_clamp;
                res_next.perm_out       = chan_clamp;
                res_next.vert_perm_out  = chan_clamp;
                res_next.horiz_perm_out = chan_clamp;
            end
            RGM_TRAPPED:
            begin
                res_next.intrinsic_perm = IW'(1);
                res_next.relative_perm  = REL_ONE;
                res_next.channel_perm   = PW'(1);
                res_next.perm_out       = ctl7_reg.item.perm;
                res_next.vert_perm_out  = ctl7_reg.item.vert_perm;
                res_next.horiz_perm_out = ctl7_reg.item.horiz_perm;
            end
            default:
            begin
                res_next.intrinsic_perm = IW'(1);
                res_next.relative_perm  = '0;
                res_next.channel_perm   = PW'(1);
                res_next.perm_out       = ctl7_reg.item.perm;
                res_next.vert_perm_out  = ctl7_reg.item.vert_perm;
                res_next.horiz_perm_out = ctl7_reg.item.horiz_perm;
            end
        endcase
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg        <= in_valid;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            res_valid_reg <= v7_reg;
        end
    end

    // Stage data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl5_reg  <= ctl5_next;
            hi5_reg   <= hi5_next;
            lo5_reg   <= lo5_next;

            ctl6_reg  <= ctl5_reg;
            intr6_reg <= intr6_next;
            r6_reg    <= r6_next;

            ctl7_reg  <= ctl6_reg;
            intr7_reg <= intr6_reg;
            pa7_reg   <= pa7_next;
            pb7_reg   <= pb7_next;

            res_reg   <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

    // Checks
    `MAGCP_ASSERT_NOW(a_chan_fanout, res_valid_reg && res_reg.regime == RGM_CHANNELS, res_reg.perm_out == res_reg.channel_perm && res_reg.vert_perm_out == res_reg.channel_perm && res_reg.horiz_perm_out == res_reg.channel_perm && res_reg.porous && res_reg.channel_marked, "channel beat without permeability fanout")
    `MAGCP_ASSERT_NOW(a_nonchan_unit, res_valid_reg && res_reg.regime != RGM_CHANNELS, res_reg.intrinsic_perm == IW'(1) && res_reg.channel_perm == PW'(1) && !res_reg.channel_marked, "non-channel beat with channel values")
    `MAGCP_ASSERT_NOW(a_trapped, res_valid_reg && res_reg.regime == RGM_TRAPPED, res_reg.fracture_mode != FM_NONE && res_reg.relative_perm == REL_ONE, "trapped beat without fracture mode")
    `MAGCP_ASSERT_NOW(a_neg_rel, res_valid_reg && res_reg.regime == RGM_CHANNELS && (res_reg.relative_perm[RW-1] || res_reg.relative_perm == '0), res_reg.channel_perm == '0, "non-positive relative gave nonzero channel permeability")
    `MAGCP_ASSERT_NEXT(a_stall_hold, res_valid_reg && !adv, res_valid_reg, "result dropped while stalled")

endmodule

/* tb/sv/magcp_result_check.sv */
`timescale 1ns / 100ps

module magcp_result_check
    import magcp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    magcp_in_if            item_bus,
    magcp_out_if           result_bus,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic           pready,
    input  logic [AW-1:0]  paddr,
    input  logic [DW-1:0]  pwdata,
    output int             errors,
    output int             pending
);

    // Q30 polynomial coefficients, highest degree first
    localparam longint CRIT_K3 = 64'sd804769497;
    localparam longint CRIT_K2 = -64'sd458273010;
    localparam longint CRIT_K1 = -64'sd174590421;
    localparam longint CRIT_K0 = 64'sd158699042;

    localparam longint REL_K4 = -64'sd2338394944;
    localparam longint REL_K3 = 64'sd5530951510;
    localparam longint REL_K2 = -64'sd4853205670;
    localparam longint REL_K1 = 64'sd1866700161;
    localparam longint REL_K0 = -64'sd264247863;

    localparam longint INTR_K3 = -64'sd57337813;
    localparam longint INTR_K2 = 64'sd116286240;
    localparam longint INTR_K1 = -64'sd80208514;
    localparam longint INTR_K0 = 64'sd18897856;

    localparam longint          HALF_LSB  = 64'sd1 <<< (FRAC_BITS - 1);
    localparam longint          INTR_CAP  = 64'sd1 <<< 32;
    localparam longint          REL_MAX   = 64'sd2147483647;
    localparam longint          REL_MIN   = -64'sd2147483648;
    localparam longint          Q30_ONE   = 64'sd1 <<< 30;
    localparam longint unsigned INTR_SAT  = (64'd1 << IW) - 64'd1;
    localparam longint unsigned Q30_MASK  = (64'd1 << 30) - 64'd1;

    cfg_t limits;
    res_t expected_q[$];

    // Q16 product, rounded half away from zero
    function automatic longint frac_mul(longint acc, longint x);
        longint p;
        p = acc * x;
        if (p >= 0)
            return (p + HALF_LSB) >>> FRAC_BITS;
        return -((HALF_LSB - p) >>> FRAC_BITS);
    endfunction

    // Horner evaluation; a zero leading term gives a cubic
    function automatic longint horner5(longint k4, k3, k2, k1, k0, longint x);
        longint acc;
        acc = k4;
        acc = frac_mul(acc, x) + k3;
        acc = frac_mul(acc, x) + k2;
        acc = frac_mul(acc, x) + k1;
        acc = frac_mul(acc, x) + k0;
        return acc;
    endfunction

    function automatic res_t predict_result(item_t it, cfg_t c);
        res_t                r;
        regime_t             rg;
        fmode_t              fm;
        longint              x;
        longint              crit;
        longint              pi;
        longint              pr;
        longint              rel;
        longint unsigned     up;
        longint unsigned     intr;
        longint unsigned     chan;
        longint unsigned     ru;
        longint unsigned     ih;
        longint unsigned     il;

        x    = longint'(it.cry);
        crit = horner5(0, CRIT_K3, CRIT_K2, CRIT_K1, CRIT_K0, x);
        if (crit < 0)
            crit = 0;
        if (crit > FONE_I)
            crit = FONE_I;

        intr = 1;
        chan = 1;
        rel  = 0;
        fm   = FM_NONE;
        r.perm_out       = it.perm;
        r.vert_perm_out  = it.vert_perm;
        r.horiz_perm_out = it.horiz_perm;

        // regime decision
        if (it.vol >= c.carrier_vol)
            rg = RGM_CARRIER;
        else if (it.cry < c.cry_lo)
            rg = RGM_SUSPENSION;
        else if (it.cry <= c.cry_hi && longint'(it.vol) >= crit && it.cryst != FONE)
            rg = RGM_CHANNELS;
        else
            rg = RGM_TRAPPED;

        if (rg == RGM_CHANNELS)
        begin
            pi = horner5(0, INTR_K3, INTR_K2, INTR_K1, INTR_K0, x);
            pr = horner5(REL_K4, REL_K3, REL_K2, REL_K1, REL_K0, x);
            if (pi < 0)
                pi = 0;
            if (pi > INTR_CAP)
                pi = INTR_CAP;
            up = pi;
            // scale by 1e18 / 2^30
            intr = up * 64'd931322574 + ((up * 64'd2521 + 64'd2048) >> 12);
            if (intr > INTR_SAT)
                intr = INTR_SAT;
            if (pr > REL_MAX)
                pr = REL_MAX;
            if (pr < REL_MIN)
                pr = REL_MIN;
            rel = pr;
            if (rel <= 0)
                chan = 0;
            else
            begin
                ru   = rel;
                ih   = intr >> 30;
                il   = intr & Q30_MASK;
                chan = ih * ru + ((il * ru + (64'd1 << 29)) >> 30);
            end
            if (chan > c.perm_cap)
                chan = c.perm_cap;
            r.perm_out       = PW'(chan);
            r.vert_perm_out  = PW'(chan);
            r.horiz_perm_out = PW'(chan);
        end
        else if (rg == RGM_TRAPPED)
        begin
            rel = Q30_ONE;
            fm  = FM_TRAPPED;
        end

        // solidified fracturing overrides trapped fracturing
        if (it.cryst >= c.solid_cryst || it.cry >= c.cry_hi ||
            (it.melt <= c.melt_lim && it.vol >= c.carrier_vol))
            fm = FM_SOLID;

        r.regime            = rg;
        r.porous            = (rg == RGM_CHANNELS || rg == RGM_TRAPPED);
        r.fracture_mode     = fm;
        r.channel_marked    = (rg == RGM_CHANNELS);
        r.critical_volatile = FW'(crit);
        r.intrinsic_perm    = IW'(intr);
        r.relative_perm     = RW'(rel);
        r.channel_perm      = PW'(chan);
        return r;
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endfunction

    // track register writes, predict on input beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin
        res_t  want;
        item_t it;
        if (!rst_n)
        begin
            limits.perm_cap    = MAX_PERM_RST;
            limits.cry_lo      = CRY_LO_RST;
            limits.cry_hi      = CRY_HI_RST;
            limits.carrier_vol = CARRIER_RST;
            limits.solid_cryst = SOLID_RST;
            limits.melt_lim    = MELT_RST;
            expected_q.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[AW-1:3]))
                    REG_MAX_PERM: limits.perm_cap    = pwdata[PW-1:0];
                    REG_CRY_LO:   limits.cry_lo      = pwdata[FW-1:0];
                    REG_CRY_HI:   limits.cry_hi      = pwdata[FW-1:0];
                    REG_CARRIER:  limits.carrier_vol = pwdata[FW-1:0];
                    REG_SOLID:    limits.solid_cryst = pwdata[FW-1:0];
                    REG_MELT:     limits.melt_lim    = pwdata[FW-1:0];
                    default: ;
                endcase
            end

            if (item_bus.valid && item_bus.ready)
            begin
                it.vol        = item_bus.volatile_frac;
                it.melt       = item_bus.melt_frac;
                it.cry        = item_bus.crystal_frac;
                it.cryst      = item_bus.crystallinity_in;
                it.perm       = item_bus.perm_in;
                it.vert_perm  = item_bus.vert_perm_in;
                it.horiz_perm = item_bus.horiz_perm_in;
                expected_q.push_back(predict_result(it, limits));
            end

            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $error("result beat with no expected result waiting");
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("regime", 64'(want.regime), 64'(result_bus.regime));
                    check_field("porous", 64'(want.porous), 64'(result_bus.porous));
                    check_field("fracture_mode", 64'(want.fracture_mode),
                                64'(result_bus.fracture_mode));
                    check_field("channel_marked", 64'(want.channel_marked),
                                64'(result_bus.channel_marked));
                    check_field("critical_volatile", 64'(want.critical_volatile),
                                64'(result_bus.critical_volatile));
                    check_field("intrinsic_perm", 64'(want.intrinsic_perm),
                                64'(result_bus.intrinsic_perm));
                    check_field("relative_perm", 64'(want.relative_perm),
                                64'(result_bus.relative_perm));
                    check_field("channel_perm", 64'(want.channel_perm),
                                64'(result_bus.channel_perm));
                    check_field("perm_out", 64'(want.perm_out), 64'(result_bus.perm_out));
                    check_field("vert_perm_out", 64'(want.vert_perm_out),
                                64'(result_bus.vert_perm_out));
                    check_field("horiz_perm_out", 64'(want.horiz_perm_out),
                                64'(result_bus.horiz_perm_out));
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import magcp_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    logic          clk   = 1'b0;
    logic          rst_n = 1'b0;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [AW-1:0] paddr;
    logic [DW-1:0] pwdata;
    logic [DW-1:0] prdata;
    logic          pready;

    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            errors;
    int            pending;
    int            quiet = 0;
    cfg_t          cfg_now;

    magcp_in_if  item_bus ();
    magcp_out_if result_bus ();

    magma_channel_permeability dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    magcp_result_check u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_bus   (item_bus),
        .result_bus (result_bus),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .errors     (errors),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver back-pressure
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: cycles without any beat or register access
    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
            (psel && penable))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        wait (quiet >= QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic item_t make_item(logic [FW-1:0] v, m, c, k, logic [PW-1:0] p, vp, hp);
        item_t it;
        it.vol        = v;
        it.melt       = m;
        it.cry        = c;
        it.cryst      = k;
        it.perm       = p;
        it.vert_perm  = vp;
        it.horiz_perm = hp;
        return it;
    endfunction

    function automatic logic [FW-1:0] random_frac();
        case ($urandom_range(9))
            0:       return '0;
            1:       return FONE;
            2:       return FW'($urandom);
            default: return FW'($urandom_range(FONE_I));
        endcase
    endfunction

    function automatic logic [PW-1:0] random_perm();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PW'({$urandom, $urandom});
        endcase
    endfunction

    // one below, at or one above a threshold
    function automatic logic [FW-1:0] near(logic [FW-1:0] lim);
        return lim + FW'($urandom_range(2)) - FW'(1);
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        it = make_item(random_frac(), random_frac(), random_frac(), random_frac(),
                       random_perm(), random_perm(), random_perm());
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            // aim at the channel window
            it.cry   = FW'($urandom_range(cfg_now.cry_hi, cfg_now.cry_lo));
            it.vol   = FW'($urandom_range(cfg_now.carrier_vol, cfg_now.carrier_vol / 2));
            it.cryst = ($urandom_range(9) == 0) ? FONE : FW'($urandom_range(FONE_I));
        end
        else if (pick < 80)
        begin
            case ($urandom_range(4))
                0: it.vol   = near(cfg_now.carrier_vol);
                1: it.cry   = near(cfg_now.cry_lo);
                2: it.cry   = near(cfg_now.cry_hi);
                3: it.cryst = near(cfg_now.solid_cryst);
                default:
                begin
                    it.melt = near(cfg_now.melt_lim);
                    it.vol  = near(cfg_now.carrier_vol);
                end
            endcase
        end
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_beat(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid            <= 1'b1;
        item_bus.volatile_frac    <= it.vol;
        item_bus.melt_frac        <= it.melt;
        item_bus.crystal_frac     <= it.cry;
        item_bus.crystallinity_in <= it.cryst;
        item_bus.perm_in          <= it.perm;
        item_bus.vert_perm_in     <= it.vert_perm;
        item_bus.horiz_perm_in    <= it.horiz_perm;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // setup then access; leaves psel high for a following write
    task automatic reg_write(input reg_idx_t idx, input logic [DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'(8 * int'(idx));
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_limits(input cfg_t c);
        reg_write(REG_MAX_PERM, DW'(c.perm_cap));
        reg_write(REG_CRY_LO, DW'(c.cry_lo));
        reg_write(REG_CRY_HI, DW'(c.cry_hi));
        reg_write(REG_CARRIER, DW'(c.carrier_vol));
        reg_write(REG_SOLID, DW'(c.solid_cryst));
        reg_write(REG_MELT, DW'(c.melt_lim));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_now = c;
    endtask

    initial
    begin
        cfg_t          lim;
        int            n_items;
        logic [PW-1:0] pa;

        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        item_bus.valid            = 1'b0;
        item_bus.volatile_frac    = '0;
        item_bus.melt_frac        = '0;
        item_bus.crystal_frac     = '0;
        item_bus.crystallinity_in = '0;
        item_bus.perm_in          = '0;
        item_bus.vert_perm_in     = '0;
        item_bus.horiz_perm_in    = '0;
        cfg_now = '{perm_cap: MAX_PERM_RST, cry_lo: CRY_LO_RST, cry_hi: CRY_HI_RST,
                    carrier_vol: CARRIER_RST, solid_cryst: SOLID_RST, melt_lim: MELT_RST};
        pa = 48'h1234_5678_9ABC;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed beats under the reset limits
        send_beat(make_item('0, '0, '0, '0, '0, '0, '0));
        send_beat(make_item('1, '1, '1, '1, '1, '1, '1));
        send_beat(make_item(FONE, '0, '0, '0, pa, pa, pa));
        send_beat(make_item(CARRIER_RST, MELT_RST, 17'd30000, '0, pa, '1, '0));
        send_beat(make_item(CARRIER_RST, MELT_RST + FW'(1), 17'd30000, '0, pa, pa, pa));
        send_beat(make_item(CARRIER_RST - FW'(1), FONE, CRY_LO_RST - FW'(1), '0, pa, pa, pa));
        send_beat(make_item(CARRIER_RST - FW'(1), FONE, CRY_LO_RST, '0, pa, pa, pa));
        send_beat(make_item(CARRIER_RST - FW'(1), FONE, CRY_HI_RST, '0, pa, pa, pa));
        send_beat(make_item(CARRIER_RST - FW'(1), FONE, CRY_HI_RST - FW'(1), '0, pa, pa, pa));
        send_beat(make_item(CARRIER_RST - FW'(1), FONE, CRY_HI_RST + FW'(1), '0, pa, pa, pa));
        send_beat(make_item(CARRIER_RST - FW'(1), '0, 17'd44000, FONE, pa, pa, pa));
        send_beat(make_item(CARRIER_RST - FW'(1), '0, 17'd44000, FONE - FW'(1), pa, pa, pa));
        send_beat(make_item(CARRIER_RST - FW'(1), '0, 17'd44000, SOLID_RST, pa, pa, pa));
        send_beat(make_item(CARRIER_RST - FW'(1), '0, 17'd44000, SOLID_RST - FW'(1),
                            pa, pa, pa));
        send_beat(make_item(17'd27000, '0, CRY_HI_RST, '0, pa, pa, pa));
        send_beat(make_item(17'd28000, '0, CRY_HI_RST, '0, pa, pa, pa));
        send_beat(make_item('0, '0, FONE, '0, pa, pa, pa));
        send_beat(make_item(17'd32000, '0, 17'd40000, '0, '0, '0, '0));
        send_beat(make_item(17'd32000, '0, 17'd42000, '0, '1, '1, '1));
        item_bus.valid <= 1'b0;

        // random phases, each with its own limits and idling
        for (int ph = 0; ph < 5; ph++)
        begin
            wait (pending == 0);
            repeat (DRAIN_CYCLES) @(negedge clk);
            n_items = 300;
            case (ph)
                0:
                begin
                    lim = '{perm_cap: '1, cry_lo: '0, cry_hi: FONE, carrier_vol: FONE,
                            solid_cryst: FONE, melt_lim: '0};
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    lim = '{perm_cap: MAX_PERM_RST, cry_lo: CRY_LO_RST, cry_hi: CRY_HI_RST,
                            carrier_vol: CARRIER_RST, solid_cryst: SOLID_RST,
                            melt_lim: MELT_RST};
                    send_idle_pct  = 88;
                    recv_stall_pct = 0;
                end
                2, 3:
                begin
                    lim.perm_cap    = (ph == 2) ? PW'($urandom_range(1 << 20, 1))
                                                : PW'({$urandom, $urandom}) | PW'(1);
                    lim.cry_lo      = FW'($urandom_range(39321, 16384));
                    lim.cry_hi      = FW'($urandom_range(FONE_I, lim.cry_lo));
                    lim.carrier_vol = FW'($urandom_range(FONE_I, 26214));
                    lim.solid_cryst = FW'($urandom_range(FONE_I, 32768));
                    lim.melt_lim    = FW'($urandom_range(FONE_I));
                    send_idle_pct   = (ph == 2) ? 0 : 30;
                    recv_stall_pct  = (ph == 2) ? 88 : 30;
                end
                default:
                begin
                    lim = '{perm_cap: PW'(1), cry_lo: FONE, cry_hi: '0, carrier_vol: '0,
                            solid_cryst: '0, melt_lim: FONE};
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    n_items        = 100;
                end
            endcase
            program_limits(lim);
            repeat (n_items)
                send_beat(random_item());
            item_bus.valid <= 1'b0;
        end

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
